// File: sv/binary_image_thinning_macros.svh
// Assertion macros shared by the thinning block's RTL.
`ifndef BINARY_IMAGE_THINNING_MACROS_SVH
`define BINARY_IMAGE_THINNING_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every clock edge outside reset.
`define BTHIN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bthin implication check failed");

// Condition that must never hold outside reset.
`define BTHIN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("bthin forbidden condition seen");

`else

`define BTHIN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTHIN_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: sv/bthin_pkg.sv
// Shared constants and types of the binary image thinning block.
package bthin_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCNT_W     = COL_W + 1;   // holds 0..MAX_WIDTH
  localparam int HCNT_W     = ROW_W + 1;   // holds 0..MAX_HEIGHT
  localparam int PAD_IW     = $clog2(MAX_WIDTH + 2);

  // Field and register widths
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 8;
  localparam int WIDTH_W  = 8;
  localparam int HEIGHT_W = 9;
  localparam int PASSES_W = 8;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 9;

  // Neighbor count bounds: a pixel is removable only strictly between these
  localparam logic [3:0] NBR_MIN = 4'd1;
  localparam logic [3:0] NBR_MAX = 4'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_THIN  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PASSES = 2'd2
  } cfg_idx_t;

  // 3x3 window around the pixel under test, snapshot values
  typedef struct packed {
    logic center;
    logic p2;  // N
    logic p3;  // NE
    logic p4;  // E
    logic p5;  // SE
    logic p6;  // S
    logic p7;  // SW
    logic p8;  // W
    logic p9;  // NW
  } nbr_t;

endpackage

// File: sv/bthin_ram.sv
// Frame store: one row per word, bit-granular write, registered row read.
module bthin_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [bthin_pkg::ROW_W-1:0]     wr_row,
  input  logic [bthin_pkg::COL_W-1:0]     wr_col,
  input  logic                            wr_bit,
  input  logic                            re,
  input  logic [bthin_pkg::ROW_W-1:0]     rd_row,
  output logic [bthin_pkg::MAX_WIDTH-1:0] rd_q
);
  import bthin_pkg::*;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  // single pixel write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
  end

  // whole row read, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_q <= mem[rd_row];
    end
  end

endmodule

// File: sv/bthin_eval.sv
// Zhang-Suen removal test for one pixel against its snapshot window.
module bthin_eval (
  input  bthin_pkg::nbr_t win,
  input  logic            second,
  output logic            clear
);
  import bthin_pkg::*;

  logic [7:0] nb;
  logic [3:0] b_cnt;
  logic [3:0] a_cnt;
  logic       guard;

  // neighbors in clockwise order, nb[0] = p2 (north)
  assign nb = {win.p9, win.p8, win.p7, win.p6, win.p5, win.p4, win.p3, win.p2};

  // set neighbors and 0-to-1 transitions around the ring
  always_comb begin
    b_cnt = 4'($countones(nb));
    a_cnt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      a_cnt = a_cnt + {3'd0, (!nb[k] && nb[(k == 7) ? 0 : k + 1])};
    end
  end

  // sub-pass specific corner conditions
  always_comb begin
    if (!second) begin
      guard = !(win.p2 & win.p4 & win.p6) && !(win.p4 & win.p6 & win.p8);
    end else begin
      guard = !(win.p2 & win.p4 & win.p8) && !(win.p2 & win.p6 & win.p8);
    end
  end

  assign clear = win.center && (b_cnt > NBR_MIN) && (b_cnt < NBR_MAX) &&
                 (a_cnt == 4'd1) && guard;

endmodule

// File: sv/binary_image_thinning.sv
// Top level of the binary image thinning block: command sequencer and sweep control.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a pixel write,
//   a pixel read or a thin command. An item is taken when in_valid is high
//   and in_stall is low; in_stall is high whenever the sequencer is busy.
//   Result channel (out_valid / out_stall) returns one result per read or
//   thin request from an output register; writes and unknown kinds answer
//   nothing. A pending result does not block further requests.
//   A write is stored in the frame store when it is accepted. A read result comes
//   from the registered row read and enters the result register once that is free.
//   A thin command sweeps the frame row by row through one shared pixel evaluator,
//   one pixel per cycle: each sub-pass primes the first row, then per row fetches
//   and loads the next and steps W pixels. The done result follows 2*P sub-passes.
//   The single-port row read of the frame store paces the sweep. Reset (rst_n low,
//   synchronous) clears the sequencer and the output valid and restores width 90,
//   height 160 and one pass; frame contents are kept. While out_stall is high the
//   result register holds; a new read or thin result waits in the sequencer until
//   the register frees up. The user must write configuration (cfg_we, cfg_index,
//   cfg_wdata) only when idle; the block itself does not enforce this.
module binary_image_thinning (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bthin_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [bthin_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bthin_pkg::KIND_W-1:0]      in_kind,
  input  logic [bthin_pkg::ROW_W-1:0]       in_row,
  input  logic [bthin_pkg::COL_W-1:0]       in_col,
  input  logic [bthin_pkg::VALUE_W-1:0]     in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_pixel,
  output logic                              out_thin_done
);
  import bthin_pkg::*;

  `include "binary_image_thinning_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RDW     = 8'b0000_0010,
    S_PRIME   = 8'b0000_0100,
    S_PRIME_W = 8'b0000_1000,
    S_FETCH   = 8'b0001_0000,
    S_FETCH_W = 8'b0010_0000,
    S_EVAL    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIDTH_W-1:0]   width_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic [PASSES_W-1:0]  passes_r;
  logic [PASSES_W-1:0]  pass_cnt_r, pass_cnt_nxt;
  logic                 sub_r, sub_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [MAX_WIDTH-1:0] up_r, mid_r, dn_r;
  logic [COL_W-1:0]     rd_col_r;
  logic                 rd_in_r;
  logic                 out_valid_r, out_pixel_r, out_thin_done_r;

  logic [WCNT_W-1:0]    w_eff;
  logic [HCNT_W-1:0]    h_eff;
  logic [MAX_WIDTH-1:0] col_mask;
  logic                 accept;
  logic                 in_inside;
  logic                 slot_free;
  logic                 row_last, col_last, dn_live;
  logic [HCNT_W-1:0]    next_row;
  logic [PASSES_W-1:0]  pass_inc;

  logic                 ram_we, ram_wbit, ram_re;
  logic [ROW_W-1:0]     ram_wrow, ram_rrow;
  logic [COL_W-1:0]     ram_wcol;
  logic [MAX_WIDTH-1:0] ram_q;

  logic [MAX_WIDTH+1:0] up_pad, mid_pad, dn_pad;
  logic [PAD_IW-1:0]    ix_w, ix_c, ix_e;
  nbr_t                 win;
  logic                 clear;

  // effective area, clipped to the frame store
  assign w_eff = (width_r > WIDTH_W'(MAX_WIDTH)) ? WCNT_W'(MAX_WIDTH) : WCNT_W'(width_r);
  assign h_eff = (height_r > HEIGHT_W'(MAX_HEIGHT)) ? HCNT_W'(MAX_HEIGHT) : HCNT_W'(height_r);

  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      col_mask[j] = WCNT_W'(j) < w_eff;
    end
  end

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_inside = (HCNT_W'(in_row) < h_eff) && (WCNT_W'(in_col) < w_eff);
  assign slot_free = !out_valid_r || !out_stall;

  // sweep position
  assign next_row = HCNT_W'(row_r) + HCNT_W'(1);
  assign dn_live  = next_row < h_eff;
  assign row_last = next_row == h_eff;
  assign col_last = (WCNT_W'(col_r) + WCNT_W'(1)) == w_eff;
  assign pass_inc = pass_cnt_r + PASSES_W'(1);

  // window taps, zero padded at both frame edges
  assign up_pad  = {1'b0, up_r, 1'b0};
  assign mid_pad = {1'b0, mid_r, 1'b0};
  assign dn_pad  = {1'b0, dn_r, 1'b0};
  assign ix_w    = PAD_IW'(col_r);
  assign ix_c    = ix_w + PAD_IW'(1);
  assign ix_e    = ix_w + PAD_IW'(2);

  always_comb begin
    win.center = mid_pad[ix_c];
    win.p2     = up_pad[ix_c];
    win.p3     = up_pad[ix_e];
    win.p4     = mid_pad[ix_e];
    win.p5     = dn_pad[ix_e];
    win.p6     = dn_pad[ix_c];
    win.p7     = dn_pad[ix_w];
    win.p8     = mid_pad[ix_w];
    win.p9     = up_pad[ix_w];
  end

  bthin_eval u_eval (
    .win    (win),
    .second (sub_r),
    .clear  (clear)
  );

  // frame store port control
  always_comb begin
    ram_we   = 1'b0;
    ram_wrow = in_row;
    ram_wcol = in_col;
    ram_wbit = in_pixel_value != '0;
    ram_re   = 1'b0;
    ram_rrow = in_row;
    case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_kind == KIND_WRITE) && in_inside;
        ram_re = accept && (in_kind == KIND_READ);
      end
      S_PRIME: begin
        ram_re   = 1'b1;
        ram_rrow = '0;
      end
      S_FETCH: begin
        ram_re   = 1'b1;
        ram_rrow = row_r + ROW_W'(1);
      end
      S_EVAL: begin
        ram_we   = clear;
        ram_wrow = row_r;
        ram_wcol = col_r;
        ram_wbit = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  bthin_ram u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_row (ram_wrow),
    .wr_col (ram_wcol),
    .wr_bit (ram_wbit),
    .re     (ram_re),
    .rd_row (ram_rrow),
    .rd_q   (ram_q)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pass_cnt_nxt = pass_cnt_r;
    sub_nxt      = sub_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_READ: begin
              state_nxt = S_RDW;
            end
            KIND_THIN: begin
              pass_cnt_nxt = '0;
              sub_nxt      = 1'b0;
              if (passes_r == '0 || w_eff == '0 || h_eff == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_PRIME;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDW: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_PRIME: begin
        state_nxt = S_PRIME_W;
      end
      S_PRIME_W: begin
        row_nxt   = '0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = S_FETCH_W;
      end
      S_FETCH_W: begin
        col_nxt   = '0;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!col_last) begin
          col_nxt = col_r + COL_W'(1);
        end else if (!row_last) begin
          row_nxt   = row_r + ROW_W'(1);
          state_nxt = S_FETCH;
        end else if (!sub_r) begin
          sub_nxt   = 1'b1;
          state_nxt = S_PRIME;
        end else begin
          sub_nxt      = 1'b0;
          pass_cnt_nxt = pass_inc;
          state_nxt    = (pass_inc == passes_r) ? S_DONE : S_PRIME;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pass_cnt_r <= '0;
      sub_r      <= 1'b0;
      width_r    <= WIDTH_W'(90);
      height_r   <= HEIGHT_W'(160);
      passes_r   <= PASSES_W'(1);
    end else begin
      state_r    <= state_nxt;
      pass_cnt_r <= pass_cnt_nxt;
      sub_r      <= sub_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
          CFG_PASSES: passes_r <= cfg_wdata[PASSES_W-1:0];
          default:    width_r  <= width_r;
        endcase
      end
    end
  end

  // sweep position and snapshot row window
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    if (state_r == S_PRIME_W) begin
      up_r  <= '0;
      mid_r <= ram_q & col_mask;
    end
    if (state_r == S_FETCH_W) begin
      dn_r <= dn_live ? (ram_q & col_mask) : '0;
    end
    if (state_r == S_EVAL && col_last) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
    end
    if (accept && in_kind == KIND_READ) begin
      rd_col_r <= in_col;
      rd_in_r  <= in_inside;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_RDW || state_r == S_DONE) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDW && slot_free) begin
      out_pixel_r     <= rd_in_r & ram_q[rd_col_r];
      out_thin_done_r <= 1'b0;
    end else if (state_r == S_DONE && slot_free) begin
      out_pixel_r     <= 1'b0;
      out_thin_done_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_thin_done = out_thin_done_r;

  // checks on the sweep
  `BTHIN_ASSERT_IMP(a_col_in_area, clk, rst_n, state_r == S_EVAL, WCNT_W'(col_r) < w_eff)
  `BTHIN_ASSERT_IMP(a_row_in_area, clk, rst_n, state_r == S_EVAL, HCNT_W'(row_r) < h_eff)
  `BTHIN_ASSERT_IMP(a_pass_bound, clk, rst_n, state_r == S_PRIME || state_r == S_EVAL, pass_cnt_r < passes_r)
  `BTHIN_ASSERT_NEVER(a_result_kind, clk, rst_n, out_valid_r && out_pixel_r && out_thin_done_r)

endmodule

// File: sim/tb_binary_image_thinning.sv
// Self-checking testbench for the binary image thinning block (Zhang-Suen skeletonization).
`timescale 1ns / 1ps

module tb_binary_image_thinning;
  import bthin_pkg::*;

  // Kind code the block drops without answering
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Longest stretch without any accepted request or result
  localparam int IDLE_LIMIT = 50000;
  // Largest area that gets painted whole before a thin request
  localparam int PAINT_MAX  = 300;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic pixel;
    logic thin_done;
  } reply_t;

  typedef struct {
    int row;
    int col;
  } spot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [ROW_W-1:0]    in_row = '0;
  logic [COL_W-1:0]    in_col = '0;
  logic [VALUE_W-1:0]  in_pixel_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_pixel;
  logic                out_thin_done;

  binary_image_thinning dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_pixel),
    .out_thin_done  (out_thin_done)
  );

  always #5 clk = ~clk;

  // Frame image as the block should hold it, plus sub-pass snapshot
  bit                  frame_img [MAX_HEIGHT][MAX_WIDTH];
  bit                  snap_img  [MAX_HEIGHT][MAX_WIDTH];
  logic [WIDTH_W-1:0]  reg_width  = 8'd90;
  logic [HEIGHT_W-1:0] reg_height = 9'd160;
  logic [PASSES_W-1:0] reg_passes = 8'd1;
  reply_t              reply_q[$];

  // Request generation: pixels written so far in request order
  cmd_t  cmd_q[$];
  bit    gen_written [MAX_HEIGHT][MAX_WIDTH];
  spot_t gen_log[$];
  int    gen_w = 90;
  int    gen_h = 160;
  int    cmds_open = 0;
  int    cmds_issued = 0;

  // Handshake bookkeeping
  bit in_taken, out_taken, out_seen_valid, in_burst, out_burst;
  int in_wait = 0, out_wait = 0;
  int accept_count = 0, seen_count = 0, idle_cycles = 0, errors = 0;

  function automatic int clip(int v, int lim);
    return v > lim ? lim : v;
  endfunction

  // Zhang-Suen passes over the in-use area; neighbors past the edge read as 0
  function automatic void sweep_thin(int eh, int ew);
    int dr[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    int dc[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    bit nb[8];
    int cnt, rise, rr, cc;
    bit drop;
    for (int it = 0; it < reg_passes; it++) begin
      for (int half = 0; half < 2; half++) begin
        for (int r = 0; r < eh; r++)
          for (int c = 0; c < ew; c++)
            snap_img[r][c] = frame_img[r][c];
        for (int r = 0; r < eh; r++) begin
          for (int c = 0; c < ew; c++) begin
            if (snap_img[r][c]) begin
              // nb[0..7]: N, NE, E, SE, S, SW, W, NW
              for (int k = 0; k < 8; k++) begin
                rr = r + dr[k];
                cc = c + dc[k];
                nb[k] = (rr >= 0 && cc >= 0 && rr < eh && cc < ew) ? snap_img[rr][cc] : 1'b0;
              end
              cnt = 0;
              rise = 0;
              for (int k = 0; k < 8; k++) begin
                cnt += nb[k];
                if (!nb[k] && nb[(k + 1) % 8]) rise++;
              end
              if (half == 0) begin
                drop = !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
              end else begin
                drop = !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
              end
              if (cnt > NBR_MIN && cnt < NBR_MAX && rise == 1 && drop) frame_img[r][c] = 1'b0;
            end
          end
        end
      end
    end
  endfunction

  // Update the frame for one accepted request and queue its reply, if any
  function automatic void frame_apply(cmd_t c);
    int eh, ew;
    bit in_area;
    reply_t r;
    eh = clip(reg_height, MAX_HEIGHT);
    ew = clip(reg_width, MAX_WIDTH);
    in_area = (c.row < eh) && (c.col < ew);
    case (c.kind)
      KIND_WRITE: begin
        if (in_area) frame_img[c.row][c.col] = (c.value != 0);
      end
      KIND_READ: begin
        r.pixel = in_area ? frame_img[c.row][c.col] : 1'b0;
        r.thin_done = 1'b0;
        reply_q.push_back(r);
      end
      KIND_THIN: begin
        sweep_thin(eh, ew);
        r.pixel = 1'b0;
        r.thin_done = 1'b1;
        reply_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // Input request side: new request at the falling edge after the gap runs out
  always @(negedge clk) begin : driver
    cmd_t c;
    logic nv;
    nv = in_valid;
    if (in_taken) begin
      nv = 1'b0;
      in_taken = 1'b0;
    end
    if (!nv) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_kind <= c.kind;
        in_row <= c.row;
        in_col <= c.col;
        in_pixel_value <= c.value;
        nv = 1'b1;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_wait = in_burst ? 0 : $urandom_range(0, 6);
      end
    end
    in_valid <= nv;
    // result side: hold each result for a drawn number of cycles
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      out_wait = out_burst ? 0 : $urandom_range(0, 6);
    end else if (out_seen_valid && out_wait > 0) begin
      out_wait--;
    end
    out_stall <= (out_wait > 0);
  end

  // Accepted requests feed the frame image; accepted results are checked
  always @(posedge clk) begin : monitor
    reply_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        frame_apply({in_kind, in_row, in_col, in_pixel_value});
        cmds_open--;
        in_taken = 1'b1;
        accept_count++;
      end
      out_seen_valid = out_valid;
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        accept_count++;
        if (reply_q.size() == 0) begin
          note_mismatch($sformatf("result with none pending: pixel=%0b thin_done=%0b",
                                  out_pixel, out_thin_done));
        end else begin
          want = reply_q.pop_front();
          if (out_pixel !== want.pixel)
            note_mismatch($sformatf("pixel: expected %0b, got %0b", want.pixel, out_pixel));
          if (out_thin_done !== want.thin_done)
            note_mismatch($sformatf("thin_done: expected %0b, got %0b",
                                    want.thin_done, out_thin_done));
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(negedge clk) begin
    if (rst_n) begin
      if (accept_count != seen_count) begin
        seen_count = accept_count;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Queue one request and track which pixels it writes
  function automatic void push_cmd(logic [KIND_W-1:0] kind, int row, int col, int value);
    cmd_t c;
    spot_t s;
    c.kind = kind;
    c.row = ROW_W'(row);
    c.col = COL_W'(col);
    c.value = VALUE_W'(value);
    cmd_q.push_back(c);
    cmds_open++;
    if (kind != KIND_UNUSED) cmds_issued++;
    if (kind == KIND_WRITE && row < gen_h && col < gen_w) begin
      gen_written[row][col] = 1'b1;
      s.row = row;
      s.col = col;
      gen_log.push_back(s);
    end
  endfunction

  // Read a pixel that has been written, or one outside the area
  function automatic void read_any();
    int r, c;
    spot_t s;
    r = $urandom_range(0, MAX_HEIGHT - 1);
    c = $urandom_range(0, MAX_WIDTH - 1);
    if ((r < gen_h && c < gen_w && !gen_written[r][c]) ||
        (gen_log.size() > 0 && $urandom_range(0, 2) != 0)) begin
      if (gen_log.size() == 0) return;
      s = gen_log[$urandom_range(0, gen_log.size() - 1)];
      r = s.row;
      c = s.col;
    end
    push_cmd(KIND_READ, r, c, 0);
  endfunction

  // Write the whole area: a few solid rectangles over sparse noise
  function automatic void paint_area();
    int nrect;
    int r0[3], r1[3], c0[3], c1[3];
    bit fg;
    nrect = $urandom_range(1, 3);
    for (int k = 0; k < nrect; k++) begin
      r0[k] = $urandom_range(0, gen_h - 1);
      r1[k] = $urandom_range(r0[k], gen_h - 1);
      c0[k] = $urandom_range(0, gen_w - 1);
      c1[k] = $urandom_range(c0[k], gen_w - 1);
    end
    for (int r = 0; r < gen_h; r++) begin
      for (int c = 0; c < gen_w; c++) begin
        fg = ($urandom_range(0, 15) == 0);
        for (int k = 0; k < nrect; k++)
          if (r >= r0[k] && r <= r1[k] && c >= c0[k] && c <= c1[k]) fg = 1'b1;
        push_cmd(KIND_WRITE, r, c, fg ? $urandom_range(1, 255) : 0);
      end
    end
  endfunction

  // A thin sweep may only touch written pixels
  function automatic bit area_complete();
    for (int r = 0; r < gen_h; r++)
      for (int c = 0; c < gen_w; c++)
        if (!gen_written[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DW'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  reg_width = WIDTH_W'(value);
      CFG_HEIGHT: reg_height = HEIGHT_W'(value);
      CFG_PASSES: reg_passes = PASSES_W'(value);
      default: ;
    endcase
  endtask

  // Wait until every request is taken and every reply has come back
  task automatic settle();
    while (cmds_open != 0 || reply_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size(int w, int h, int passes);
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PASSES, passes);
    gen_w = clip(w, MAX_WIDTH);
    gen_h = clip(h, MAX_HEIGHT);
  endtask

  task automatic random_phase(int w, int h, int passes, int n);
    int goal, sel, area;
    set_size(w, h, passes);
    area = gen_w * gen_h;
    goal = cmds_issued + n;
    while (cmds_issued < goal) begin
      sel = $urandom_range(0, 9);
      if (sel < 4 && area > 0 && area <= PAINT_MAX) begin
        // paint shapes, thin them, then sample the skeleton
        paint_area();
        push_cmd(KIND_THIN, 0, 0, 0);
        repeat ($urandom_range(1, 6)) read_any();
      end else if (sel < 6) begin
        if (area > 0 && $urandom_range(0, 4) < 3)
          push_cmd(KIND_WRITE, $urandom_range(0, gen_h - 1), $urandom_range(0, gen_w - 1),
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : 0);
        else
          push_cmd(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 127),
                   $urandom_range(0, 255));
      end else if (sel < 8) begin
        read_any();
      end else if (sel == 8 && area_complete()) begin
        push_cmd(KIND_THIN, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 255));
      end else begin
        push_cmd(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset geometry 90 x 160: corners, writes and reads past the edges, unused kind
    push_cmd(KIND_WRITE, 0, 0, 8'hFF);
    push_cmd(KIND_WRITE, 159, 89, 8'h01);
    push_cmd(KIND_WRITE, 159, 90, 8'h80);
    push_cmd(KIND_WRITE, 160, 0, 8'h55);
    push_cmd(KIND_WRITE, 255, 127, 8'hAA);
    push_cmd(KIND_UNUSED, 3, 3, 8'hFF);
    push_cmd(KIND_READ, 0, 0, 0);
    push_cmd(KIND_READ, 159, 89, 0);
    push_cmd(KIND_READ, 255, 127, 0);
    push_cmd(KIND_READ, 160, 0, 0);
    push_cmd(KIND_WRITE, 0, 0, 8'h00);
    push_cmd(KIND_READ, 0, 0, 0);

    // Solid 3x3 block with zero passes: thin answers done and changes nothing
    set_size(3, 3, 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        push_cmd(KIND_WRITE, r, c, 8'h7F);
    push_cmd(KIND_THIN, 0, 0, 0);
    push_cmd(KIND_READ, 1, 1, 0);

    // Random phases: small areas, empty areas, edge sizes, clipped sizes, many passes
    random_phase(5, 5, 1, 60);
    random_phase(0, 7, 1, 30);
    random_phase(4, 0, 2, 25);
    random_phase(128, 2, 1, 250);
    random_phase(1, 256, 1, 250);
    random_phase(255, 1, 2, 130);
    random_phase(1, 511, 1, 40);
    random_phase(2, 2, 255, 40);
    random_phase(12, 10, 3, 120);
    random_phase(128, 256, 1, 40);
    random_phase(3, 3, 1, 40);
    random_phase(7, 9, 2, 60);

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
